// ===== sv/pdsp_pkg.sv =====
// Shared types, constants and helper functions of the USB-PD sink message policy.
`default_nettype none

package pdsp_pkg;

  localparam int unsigned MAX_OBJECTS = 7;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input opcodes
  localparam logic [1:0] OP_HEADER = 2'd0;
  localparam logic [1:0] OP_OBJECT = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_REQUEST_VOLTS = 2'd0;
  localparam logic [1:0] CFG_SPEC_REVISION = 2'd1;
  localparam logic [1:0] CFG_AMS_TIMEOUT   = 2'd2;

  // control message types
  localparam logic [4:0] T_GOODCRC       = 5'd1;
  localparam logic [4:0] T_ACCEPT        = 5'd3;
  localparam logic [4:0] T_PS_RDY        = 5'd6;
  localparam logic [4:0] T_GET_SINK_CAP  = 5'd8;
  localparam logic [4:0] T_SOFT_RESET    = 5'd13;
  localparam logic [4:0] T_NOT_SUPPORTED = 5'd16;
  // data message types
  localparam logic [4:0] T_SOURCE_CAP    = 5'd1;
  localparam logic [4:0] T_REQUEST       = 5'd2;
  localparam logic [4:0] T_SINK_CAP      = 5'd4;

  localparam logic [31:0] SINK_PDO     = 32'h0401_91F4;
  localparam logic [31:0] REQ_TEMPLATE = 32'h0300_0000;

  localparam logic [1:0] PDO_AUGMENTED = 2'd3;

  // contract phase / policy_state codes
  localparam logic [1:0] PHASE_DEFAULT    = 2'd0;
  localparam logic [1:0] PHASE_TRANSITION = 2'd1;
  localparam logic [1:0] PHASE_EXPLICIT   = 2'd2;

  localparam logic [3:0] NO_RX_ID = 4'd8;

  // 1/20 as 3277/65536, exact for 10-bit operands
  localparam logic [11:0] DIV20_MUL = 12'd3277;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_OBJECT = 2'd1,
    KIND_TICK   = 2'd2
  } pdsp_kind_e;

  typedef struct packed {
    logic [1:0] ptype;
    logic [9:0] max_v;
    logic [9:0] min_v;
    logic [9:0] max_p;
    logic [9:0] max_i;
  } pdsp_contract_t;

  typedef struct packed {
    pdsp_kind_e     kind;
    logic [4:0]     hdr_type;
    logic [2:0]     msg_id;
    logic [2:0]     obj_count;
    pdsp_contract_t pdo;
    logic           pdo_aug;
    logic [5:0]     pdo_volts;
  } pdsp_cmd_t;

  typedef struct packed {
    logic [5:0]  request_volts;
    logic [1:0]  spec_revision;
    logic [15:0] ams_timeout_ticks;
  } pdsp_cfg_t;

  typedef struct packed {
    logic        handled;
    logic        send_valid;
    logic [15:0] tx_header;
    logic        tx_has_object;
    logic [31:0] tx_object;
    logic [1:0]  policy_state;
    logic [5:0]  contract_volts;
    logic        ams_active;
  } pdsp_result_t;

  function automatic logic [5:0] div20(input logic [9:0] x);
    logic [21:0] prod;
    prod = {12'd0, x} * {10'd0, DIV20_MUL};
    return prod[21:16];
  endfunction

  function automatic pdsp_contract_t parse_pdo(input logic [31:0] p);
    pdsp_contract_t c;
    c       = '0;
    c.ptype = p[31:30];
    unique case (p[31:30])
      2'd0: begin
        c.max_v = p[19:10];
        c.max_i = p[9:0];
      end
      2'd1: begin
        c.min_v = p[19:10];
        c.max_v = p[29:20];
        c.max_p = p[9:0];
      end
      2'd2: begin
        c.min_v = p[19:10];
        c.max_v = p[29:20];
        c.max_i = p[9:0];
      end
      default: begin
        c.max_v = {1'b0, p[24:17], 1'b0};
        c.min_v = {1'b0, p[15:8], 1'b0};
        c.max_i = {1'b0, p[6:0], 2'b00} + {3'b000, p[6:0]};
      end
    endcase
    return c;
  endfunction

  function automatic logic [15:0] make_header(input logic [4:0] mtype, input logic [1:0] rev,
                                              input logic [2:0] id, input logic [2:0] count);
    return {1'b0, count, id, 1'b0, rev, 1'b0, mtype};
  endfunction

endpackage

`default_nettype wire

// ===== sv/pdsp_if.sv =====
// Handshake channels for received items and for result beats.
`default_nettype none

interface pdsp_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] rx_header;
  logic [31:0] rx_object;

  modport source (output valid, output opcode, output rx_header, output rx_object,
                  input ready);
  modport sink (input valid, input opcode, input rx_header, input rx_object,
                output ready);
endinterface

interface pdsp_result_if;
  logic        valid;
  logic        ready;
  logic        handled;
  logic        send_valid;
  logic [15:0] tx_header;
  logic        tx_has_object;
  logic [31:0] tx_object;
  logic [1:0]  policy_state;
  logic [5:0]  contract_volts;
  logic        ams_active;

  modport source (output valid, output handled, output send_valid, output tx_header,
                  output tx_has_object, output tx_object, output policy_state,
                  output contract_volts, output ams_active, input ready);
  modport sink (input valid, input handled, input send_valid, input tx_header,
                input tx_has_object, input tx_object, input policy_state,
                input contract_volts, input ams_active, output ready);
endinterface

`default_nettype wire

// ===== sv/pdsp_front.sv =====
// Front end: accepts input beats, splits headers and decodes PDOs into commands.
`default_nettype none

module pdsp_front
  import pdsp_pkg::*;
(
  pdsp_item_if.sink  item_i,
  input  logic       q_ready_i,
  output logic       push_o,
  output pdsp_cmd_t  cmd_o
);

  pdsp_contract_t pdo;
  logic           known_op;

  assign pdo          = parse_pdo(item_i.rx_object);
  assign item_i.ready = q_ready_i;
  assign push_o       = item_i.valid && q_ready_i && known_op;

  always_comb begin
    known_op = 1'b1;
    cmd_o.kind = KIND_TICK;
    unique case (item_i.opcode)
      OP_HEADER: cmd_o.kind = KIND_HEADER;
      OP_OBJECT: cmd_o.kind = KIND_OBJECT;
      OP_TICK:   cmd_o.kind = KIND_TICK;
      default:   known_op = 1'b0;
    endcase
    cmd_o.hdr_type  = item_i.rx_header[4:0];
    cmd_o.msg_id    = item_i.rx_header[11:9];
    cmd_o.obj_count = item_i.rx_header[14:12];
    cmd_o.pdo       = pdo;
    cmd_o.pdo_aug   = (pdo.ptype == PDO_AUGMENTED);
    cmd_o.pdo_volts = div20(pdo.max_v);
  end

endmodule

`default_nettype wire

// ===== sv/pdsp_queue.sv =====
// Short command queue between the front end and the policy back end.
`default_nettype none

module pdsp_queue
  import pdsp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pdsp_cmd_t cmd_i,
  output logic      ready_o,
  input  logic      pop_i,
  output logic      valid_o,
  output pdsp_cmd_t cmd_o
);

  pdsp_cmd_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  count_q, count_d;
  logic               do_push, do_pop;

  assign ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pdsp_back.sv =====
// Back end: message policy state, PDO selection, replies and the result register.
`default_nettype none

module pdsp_back
  import pdsp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pdsp_cfg_t     cfg_i,
  input  logic          q_valid_i,
  input  pdsp_cmd_t     cmd_i,
  output logic          pop_o,
  pdsp_result_if.source result_o
);

  logic [2:0]     tx_cnt_q, tx_cnt_d;
  logic [3:0]     last_id_q, last_id_d;
  logic           ams_q, ams_d;
  logic [15:0]    elapsed_q, elapsed_d;
  logic [1:0]     phase_q, phase_d;
  logic [2:0]     left_q, left_d;
  logic [2:0]     index_q, index_d;
  logic [4:0]     rx_type_q, rx_type_d;
  logic           dropped_q, dropped_d;
  logic           found_q, found_d;
  logic [2:0]     pos_q, pos_d;
  pdsp_contract_t sel_q, sel_d;
  logic [5:0]     sel_volts_q, sel_volts_d;
  pdsp_contract_t reqw_q, reqw_d;
  logic [5:0]     req_volts_q, req_volts_d;
  pdsp_contract_t accw_q, accw_d;
  logic [5:0]     acc_volts_q, acc_volts_d;

  logic           out_valid_q, out_valid_d;
  pdsp_result_t   out_q, out_d;
  logic           emit;
  logic [16:0]    tick_next;
  logic [9:0]     req_cur;
  logic [2:0]     req_pos;

  assign pop_o = q_valid_i && (!out_valid_q || result_o.ready);

  always_comb begin
    tx_cnt_d    = tx_cnt_q;
    last_id_d   = last_id_q;
    ams_d       = ams_q;
    elapsed_d   = elapsed_q;
    phase_d     = phase_q;
    left_d      = left_q;
    index_d     = index_q;
    rx_type_d   = rx_type_q;
    dropped_d   = dropped_q;
    found_d     = found_q;
    pos_d       = pos_q;
    sel_d       = sel_q;
    sel_volts_d = sel_volts_q;
    reqw_d      = reqw_q;
    req_volts_d = req_volts_q;
    accw_d      = accw_q;
    acc_volts_d = acc_volts_q;
    emit        = 1'b0;
    out_d       = '0;
    tick_next   = {1'b0, elapsed_q} + 17'd1;
    req_cur     = '0;
    req_pos     = '0;

    if (pop_o) begin
      unique case (cmd_i.kind)
        KIND_HEADER: begin
          left_d = '0;
          if (cmd_i.obj_count == 3'd0) begin
            emit = 1'b1;
            out_d.handled = 1'b1;
            if (cmd_i.hdr_type == T_GOODCRC) begin
              tx_cnt_d = tx_cnt_q + 3'd1;
            end else if ({1'b0, cmd_i.msg_id} == last_id_q) begin
              out_d.handled = 1'b0;
            end else begin
              last_id_d = {1'b0, cmd_i.msg_id};
              unique case (cmd_i.hdr_type)
                T_ACCEPT: begin
                  if (ams_q) begin
                    if (reqw_q != accw_q) phase_d = PHASE_TRANSITION;
                    accw_d      = reqw_q;
                    acc_volts_d = req_volts_q;
                  end
                end
                T_PS_RDY: begin
                  ams_d   = 1'b0;
                  phase_d = PHASE_EXPLICIT;
                end
                T_SOFT_RESET: begin
                  phase_d = PHASE_DEFAULT;
                  tx_cnt_d = '0;
                  out_d.send_valid = 1'b1;
                  out_d.tx_header  = make_header(T_ACCEPT, cfg_i.spec_revision, 3'd0, 3'd0);
                end
                T_GET_SINK_CAP: begin
                  out_d.send_valid    = 1'b1;
                  out_d.tx_header     = make_header(T_SINK_CAP, cfg_i.spec_revision,
                                                    tx_cnt_q, 3'd1);
                  out_d.tx_has_object = 1'b1;
                  out_d.tx_object     = SINK_PDO;
                end
                default: begin
                  out_d.send_valid = 1'b1;
                  out_d.tx_header  = make_header(T_NOT_SUPPORTED, cfg_i.spec_revision,
                                                 tx_cnt_q, 3'd0);
                end
              endcase
            end
          end else begin
            dropped_d = ({1'b0, cmd_i.msg_id} == last_id_q);
            if (!dropped_d) last_id_d = {1'b0, cmd_i.msg_id};
            rx_type_d   = cmd_i.hdr_type;
            left_d      = cmd_i.obj_count;
            index_d     = '0;
            found_d     = 1'b0;
            pos_d       = '0;
            sel_d       = '0;
            sel_volts_d = '0;
          end
        end
        KIND_OBJECT: begin
          if (left_q != 3'd0) begin
            if (!dropped_q && rx_type_q == T_SOURCE_CAP && index_q < 3'(MAX_OBJECTS) &&
                !cmd_i.pdo_aug && (cmd_i.pdo_volts <= cfg_i.request_volts || !found_q)) begin
              sel_d       = cmd_i.pdo;
              sel_volts_d = cmd_i.pdo_volts;
              pos_d       = index_q;
              found_d     = 1'b1;
            end
            index_d = index_q + 3'd1;
            left_d  = left_q - 3'd1;
            if (left_q == 3'd1) begin
              emit = 1'b1;
              if (dropped_q) begin
                out_d.handled = 1'b0;
              end else if (rx_type_q == T_SOURCE_CAP) begin
                ams_d       = 1'b1;
                elapsed_d   = '0;
                reqw_d      = sel_d;
                req_volts_d = sel_volts_d;
                if (found_d) begin
                  req_cur = (sel_d.max_i != 10'd0) ? sel_d.max_i : sel_d.max_p;
                  req_pos = pos_d + 3'd1;
                end
                out_d.handled       = 1'b1;
                out_d.send_valid    = 1'b1;
                out_d.tx_header     = make_header(T_REQUEST, cfg_i.spec_revision,
                                                  tx_cnt_q, 3'd1);
                out_d.tx_has_object = 1'b1;
                out_d.tx_object     = REQ_TEMPLATE | {22'd0, req_cur} |
                                      {12'd0, req_cur, 10'd0} | {1'b0, req_pos, 28'd0};
              end else begin
                out_d.handled = 1'b1;
              end
            end
          end
        end
        KIND_TICK: begin
          if (ams_q) begin
            if (tick_next > {1'b0, cfg_i.ams_timeout_ticks}) begin
              ams_d     = 1'b0;
              elapsed_d = '0;
            end else begin
              elapsed_d = tick_next[15:0];
            end
          end
        end
        default: ;
      endcase
    end

    out_d.policy_state   = phase_d;
    out_d.contract_volts = acc_volts_d;
    out_d.ams_active     = ams_d;

    out_valid_d = out_valid_q && !result_o.ready;
    if (emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_cnt_q    <= '0;
      last_id_q   <= NO_RX_ID;
      ams_q       <= 1'b0;
      elapsed_q   <= '0;
      phase_q     <= PHASE_DEFAULT;
      left_q      <= '0;
      index_q     <= '0;
      rx_type_q   <= '0;
      dropped_q   <= 1'b0;
      found_q     <= 1'b0;
      pos_q       <= '0;
      sel_q       <= '0;
      sel_volts_q <= '0;
      reqw_q      <= '0;
      req_volts_q <= '0;
      accw_q      <= '0;
      acc_volts_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tx_cnt_q    <= tx_cnt_d;
      last_id_q   <= last_id_d;
      ams_q       <= ams_d;
      elapsed_q   <= elapsed_d;
      phase_q     <= phase_d;
      left_q      <= left_d;
      index_q     <= index_d;
      rx_type_q   <= rx_type_d;
      dropped_q   <= dropped_d;
      found_q     <= found_d;
      pos_q       <= pos_d;
      sel_q       <= sel_d;
      sel_volts_q <= sel_volts_d;
      reqw_q      <= reqw_d;
      req_volts_q <= req_volts_d;
      accw_q      <= accw_d;
      acc_volts_q <= acc_volts_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.handled        = out_q.handled;
  assign result_o.send_valid     = out_q.send_valid;
  assign result_o.tx_header      = out_q.tx_header;
  assign result_o.tx_has_object  = out_q.tx_has_object;
  assign result_o.tx_object      = out_q.tx_object;
  assign result_o.policy_state   = out_q.policy_state;
  assign result_o.contract_volts = out_q.contract_volts;
  assign result_o.ams_active     = out_q.ams_active;

endmodule

`default_nettype wire

// ===== sv/usb_pd_sink_message_policy.sv =====
// Top level of the USB-PD sink message policy: config registers, front end, queue, back end.
// item_i carries one beat per received header (opcode 0), data object (opcode 1)
//   or 1 ms tick (opcode 2); opcode 3 beats are taken and ignored.
// result_o carries one beat per completed message: handled/dropped, an optional
//   reply (header plus at most one data object) and the contract and AMS status.
// Headers with objects, the objects before the last one, and ticks give no beat.
// A taken beat is written into the command queue; the back end pops it, updates the
//   policy state and registers any result beat in its output register. One input
//   beat per cycle is taken while result_o does not stall; the queue holds two entries.
// The cfg port writes request_volts, spec_revision and ams_timeout_ticks at the
//   edge where cfg_we_i is high; indexes past the last register are ignored.
// Reset (rst_ni low, asynchronous) restores the register defaults and the policy
//   state; no clearing pass is needed, the block takes beats right after reset.
// When result_o stalls, the output register holds its beat, the queue fills and
//   item_i.ready drops after at most two more beats; nothing is lost.
`default_nettype none

module usb_pd_sink_message_policy
  import pdsp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  pdsp_item_if.sink     item_i,
  pdsp_result_if.source result_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  pdsp_cfg_t cfg_q, cfg_d;
  pdsp_cmd_t front_cmd, queue_cmd;
  logic      front_push, queue_ready, queue_valid, back_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_REQUEST_VOLTS: cfg_d.request_volts     = cfg_data_i[5:0];
        CFG_SPEC_REVISION: cfg_d.spec_revision     = cfg_data_i[1:0];
        CFG_AMS_TIMEOUT:   cfg_d.ams_timeout_ticks = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.request_volts     <= 6'd5;
      cfg_q.spec_revision     <= 2'd1;
      cfg_q.ams_timeout_ticks <= 16'd2000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pdsp_front u_front (
    .item_i    (item_i),
    .q_ready_i (queue_ready),
    .push_o    (front_push),
    .cmd_o     (front_cmd)
  );

  pdsp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .cmd_i   (front_cmd),
    .ready_o (queue_ready),
    .pop_i   (back_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  pdsp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (queue_valid),
    .cmd_i     (queue_cmd),
    .pop_o     (back_pop),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire
